[hw/rtl/hdf_pkg.sv]
// ----------------------------------------------------------------------------
// hdf_pkg
// Shared types, result kinds, register indexes and header capture layout
// for the header deframer.
// ----------------------------------------------------------------------------
package hdf_pkg;

   localparam int BYTE_W     = 8;
   localparam int POS_W      = 7;
   localparam int KIND_W     = 3;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam logic [KIND_W-1:0] KIND_HEADER    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FILE      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RECEIPT   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_UNMATCHED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_IGNORED   = 3'd5;

   typedef enum logic [2:0] {
      PH_COLLECT = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_IGNORE  = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      REG_FILE_KEY_LOW    = 2'd0,
      REG_FILE_KEY_HIGH   = 2'd1,
      REG_RECEIPT_KEY_LOW = 2'd2,
      REG_RECEIPT_KEY_HIGH = 2'd3
   } reg_index_type;

   // capture slots: header bytes 0..11, 50..61 and 82..109
   localparam int CAP_SLOTS       = 52;
   localparam int SLOT_KEY        = 0;
   localparam int SLOT_RCPT_TYPE  = 12;
   localparam int SLOT_RCPT_ERROR = 16;
   localparam int SLOT_RCPT_PORT  = 20;
   localparam int SLOT_FILE_SIZE  = 24;
   localparam int SLOT_START_OFF  = 32;
   localparam int SLOT_PART_INDEX = 40;
   localparam int SLOT_PART_COUNT = 44;
   localparam int SLOT_FILE_PORT  = 48;

   function automatic int cap_pos(input int slot);
      int p;
      if (slot < 12) begin
         p = slot;
      end else if (slot < 24) begin
         p = slot + 38;
      end else begin
         p = slot + 58;
      end
      return p;
   endfunction

   typedef struct packed {
      logic [63:0] file_lo;
      logic [31:0] file_hi;
      logic [63:0] rcpt_lo;
      logic [31:0] rcpt_hi;
   } key_cfg_type;

   typedef struct packed {
      logic        is_file;
      logic        is_rcpt;
      logic [63:0] file_size;
      logic [63:0] start_offset;
      logic [31:0] part_index;
      logic [31:0] part_count;
      logic [31:0] file_port;
      logic [31:0] rcpt_type;
      logic [31:0] rcpt_error;
      logic [31:0] rcpt_port;
   } hdr_fields_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] out_byte;
      logic [POS_W-1:0]  header_pos;
      logic [63:0]       write_offset;
      logic [63:0]       file_size;
      logic [31:0]       part_index;
      logic [31:0]       part_count;
      logic [31:0]       reply_port;
      logic [31:0]       receipt_type;
      logic [31:0]       receipt_error;
   } rsp_payload_type;

endpackage

[hw/rtl/hdf_ifs.sv]
// ----------------------------------------------------------------------------
// hdf_ifs
// Valid/ready channels for the byte input and the result output.
// ----------------------------------------------------------------------------
interface hdf_req_if import hdf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface hdf_rsp_if import hdf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] out_byte;
   logic [POS_W-1:0]  header_pos;
   logic [63:0]       write_offset;
   logic [63:0]       file_size;
   logic [31:0]       part_index;
   logic [31:0]       part_count;
   logic [31:0]       reply_port;
   logic [31:0]       receipt_type;
   logic [31:0]       receipt_error;

   modport source (output valid, output kind, output out_byte, output header_pos,
                   output write_offset, output file_size, output part_index,
                   output part_count, output reply_port, output receipt_type,
                   output receipt_error, input ready);
   modport sink (input valid, input kind, input out_byte, input header_pos,
                 input write_offset, input file_size, input part_index,
                 input part_count, input reply_port, input receipt_type,
                 input receipt_error, output ready);
endinterface

[hw/rtl/hdf_csr.sv]
// ----------------------------------------------------------------------------
// hdf_csr
// APB register block holding the file and receipt keywords.
// ----------------------------------------------------------------------------
module hdf_csr import hdf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output key_cfg_type           keys
);

   key_cfg_type   keys_ff;
   reg_index_type reg_sel;
   logic          wr_en;

   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[4:3]);
   assign wr_en   = psel && penable && pwrite;
   assign keys    = keys_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_FILE_KEY_LOW:     keys_ff.file_lo <= pwdata;
            REG_FILE_KEY_HIGH:    keys_ff.file_hi <= pwdata[31:0];
            REG_RECEIPT_KEY_LOW:  keys_ff.rcpt_lo <= pwdata;
            REG_RECEIPT_KEY_HIGH: keys_ff.rcpt_hi <= pwdata[31:0];
            default:              keys_ff <= keys_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_FILE_KEY_LOW:     prdata = keys_ff.file_lo;
         REG_FILE_KEY_HIGH:    prdata = {32'd0, keys_ff.file_hi};
         REG_RECEIPT_KEY_LOW:  prdata = keys_ff.rcpt_lo;
         REG_RECEIPT_KEY_HIGH: prdata = {32'd0, keys_ff.rcpt_hi};
         default:              prdata = '0;
      endcase
   end

endmodule

[hw/rtl/hdf_capture.sv]
// ----------------------------------------------------------------------------
// hdf_capture
// Captures the header bytes that carry keyword and fields, and decodes the
// header on its last byte.
// ----------------------------------------------------------------------------
module hdf_capture import hdf_pkg::*; #(
   parameter int HEADER_BYTES = 110,
   localparam int CNT_W = $clog2(HEADER_BYTES)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [CNT_W-1:0]  pos,
   input  logic [BYTE_W-1:0] in_byte,
   input  key_cfg_type       keys,
   output hdr_fields_type    fields
);

   logic [BYTE_W-1:0]          cap_ff [CAP_SLOTS];
   logic [BYTE_W*CAP_SLOTS-1:0] cur;
   logic [95:0]                 key_bytes;

   always_ff @(posedge clock) begin
      for (int k = 0; k < CAP_SLOTS; k++) begin
         if (wr_en && pos == CNT_W'(cap_pos(k))) begin
            cap_ff[k] <= in_byte;
         end
      end
   end

   // the last header byte is still on its way in
   always_comb begin
      for (int k = 0; k < CAP_SLOTS; k++) begin
         cur[BYTE_W*k +: BYTE_W] = (cap_pos(k) == HEADER_BYTES - 1) ? in_byte : cap_ff[k];
      end
   end

   assign key_bytes = cur[BYTE_W*SLOT_KEY +: 96];

   always_comb begin
      fields.is_file      = key_bytes == {keys.file_hi, keys.file_lo};
      fields.is_rcpt      = key_bytes == {keys.rcpt_hi, keys.rcpt_lo};
      fields.file_size    = cur[BYTE_W*SLOT_FILE_SIZE +: 64];
      fields.start_offset = cur[BYTE_W*SLOT_START_OFF +: 64];
      fields.part_index   = cur[BYTE_W*SLOT_PART_INDEX +: 32];
      fields.part_count   = cur[BYTE_W*SLOT_PART_COUNT +: 32];
      fields.file_port    = cur[BYTE_W*SLOT_FILE_PORT +: 32];
      fields.rcpt_type    = cur[BYTE_W*SLOT_RCPT_TYPE +: 32];
      fields.rcpt_error   = cur[BYTE_W*SLOT_RCPT_ERROR +: 32];
      fields.rcpt_port    = cur[BYTE_W*SLOT_RCPT_PORT +: 32];
   end

endmodule

[hw/rtl/header_deframer_with_offset.sv]
// ----------------------------------------------------------------------------
// header_deframer_with_offset
// Each byte is registered in the input stage, then in the result stage.
// Throughput: one byte per cycle while results are taken without stall,
// set by the single input and result stage.
// Reset clears the keywords, header count, phase, offset and both stages;
// no clearing pass, bytes are taken from the first cycle after reset.
// Splits a byte stream into a 110-byte header and payload or ignored bytes.
// ----------------------------------------------------------------------------
module header_deframer_with_offset import hdf_pkg::*; #(
   parameter int HEADER_BYTES = 110
) (
   input  logic                  clock,
   input  logic                  reset,
   hdf_req_if.sink               req_bus,
   hdf_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int CNT_W = $clog2(HEADER_BYTES);
   localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(HEADER_BYTES - 1);

   key_cfg_type     keys;
   hdr_fields_type  fields;

   logic              s0_valid_ff;
   logic [BYTE_W-1:0] s0_byte_ff;
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_ff;
   rsp_payload_type   rsp_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   phase_type         phase_ff;
   phase_type         phase_in;
   logic [63:0]       offset_ff;
   logic [63:0]       offset_in;
   logic              advance;
   logic              cap_wr;

   hdf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .keys    (keys)
   );

   hdf_capture #(.HEADER_BYTES(HEADER_BYTES)) u_capture (
      .clock   (clock),
      .wr_en   (cap_wr),
      .pos     (count_ff),
      .in_byte (s0_byte_ff),
      .keys    (keys),
      .fields  (fields)
   );

   assign advance       = s0_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s0_valid_ff || advance;
   assign cap_wr        = advance && (phase_ff == PH_COLLECT);

   always_comb begin
      rsp_in          = '0;
      rsp_in.out_byte = s0_byte_ff;
      count_in        = count_ff;
      phase_in        = phase_ff;
      offset_in       = offset_ff;
      unique case (phase_ff)
         PH_COLLECT: begin
            rsp_in.header_pos = count_ff[POS_W-1:0];
            if (count_ff != LAST_POS) begin
               rsp_in.kind = KIND_HEADER;
               count_in    = count_ff + CNT_W'(1);
            end else begin
               count_in = '0;
               if (fields.is_rcpt) begin
                  rsp_in.receipt_type  = fields.rcpt_type;
                  rsp_in.receipt_error = fields.rcpt_error;
                  rsp_in.reply_port    = fields.rcpt_port;
               end
               if (fields.is_file) begin
                  rsp_in.kind         = KIND_FILE;
                  rsp_in.file_size    = fields.file_size;
                  rsp_in.write_offset = fields.start_offset;
                  rsp_in.part_index   = fields.part_index;
                  rsp_in.part_count   = fields.part_count;
                  rsp_in.reply_port   = fields.file_port;
                  offset_in           = fields.start_offset;
                  phase_in            = PH_PAYLOAD;
               end else if (fields.is_rcpt) begin
                  rsp_in.kind = KIND_RECEIPT;
                  phase_in    = PH_IGNORE;
               end else begin
                  rsp_in.kind = KIND_UNMATCHED;
                  phase_in    = PH_IGNORE;
               end
            end
         end
         PH_PAYLOAD: begin
            rsp_in.kind         = KIND_PAYLOAD;
            rsp_in.write_offset = offset_ff;
            offset_in           = offset_ff + 64'd1;
         end
         default: begin
            rsp_in.kind = KIND_IGNORED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         phase_ff     <= PH_COLLECT;
         offset_ff    <= '0;
      end else begin
         if (req_bus.ready) begin
            s0_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= count_in;
            phase_ff     <= phase_in;
            offset_ff    <= offset_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s0_byte_ff <= req_bus.in_byte;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.kind          = rsp_ff.kind;
   assign rsp_bus.out_byte      = rsp_ff.out_byte;
   assign rsp_bus.header_pos    = rsp_ff.header_pos;
   assign rsp_bus.write_offset  = rsp_ff.write_offset;
   assign rsp_bus.file_size     = rsp_ff.file_size;
   assign rsp_bus.part_index    = rsp_ff.part_index;
   assign rsp_bus.part_count    = rsp_ff.part_count;
   assign rsp_bus.reply_port    = rsp_ff.reply_port;
   assign rsp_bus.receipt_type  = rsp_ff.receipt_type;
   assign rsp_bus.receipt_error = rsp_ff.receipt_error;

endmodule

[hw/rtl/hdf_checker.sv]
// ----------------------------------------------------------------------------
// hdf_checker
// Port-level checks on the deframer results and the register port.
// ----------------------------------------------------------------------------
module hdf_checker import hdf_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [KIND_W-1:0] rsp_kind,
   input logic [POS_W-1:0]  rsp_header_pos,
   input logic [63:0]       rsp_write_offset,
   input logic [63:0]       rsp_file_size,
   input logic              pready
);

   a_reset_clears_valid: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("stalled result changed");

   a_pos_zero_outside_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_PAYLOAD || rsp_kind == KIND_IGNORED)
      |-> rsp_header_pos == '0)
      else $error("header position outside header");

   a_header_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_HEADER |-> rsp_write_offset == '0 && rsp_file_size == '0)
      else $error("file fields on header byte");

   a_pready_high: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind header_deframer_with_offset hdf_checker u_hdf_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_kind         (rsp_bus.kind),
   .rsp_header_pos   (rsp_bus.header_pos),
   .rsp_write_offset (rsp_bus.write_offset),
   .rsp_file_size    (rsp_bus.file_size),
   .pready           (pready)
);

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives one connection stream into the header deframer: a 110-byte header
// built for a randomly picked header case (file, file and receipt both
// matching, receipt, unknown), then a long run of payload or ignored bytes.
// Every result is checked field by field against an in-bench model of the
// deframer, under random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module testbench;
   import hdf_pkg::*;

   localparam int HDR_LEN     = 110;
   localparam int STALL_LIMIT = 2000;
   localparam int MID_BYTES   = 900;
   localparam int TAIL_BYTES  = 938;
   localparam int HOLD_CYCLES = 200;

   typedef enum int {
      HDR_FILE,
      HDR_BOTH,
      HDR_RECEIPT,
      HDR_UNKNOWN
   } hdr_case_type;

   class deframe_scoreboard;
      key_cfg_type       keys;
      logic [7:0]        hdr_seen [HDR_LEN];
      int unsigned       hdr_count;
      phase_type         ph;
      logic [63:0]       next_offset;
      rsp_payload_type   expected_q[$];
      int                errors;
      int                kind_count [6];

      function new();
         keys        = '0;
         hdr_count   = 0;
         ph          = PH_COLLECT;
         next_offset = '0;
         errors      = 0;
         foreach (kind_count[k]) kind_count[k] = 0;
      endfunction

      function void set_key(reg_index_type idx, logic [63:0] value);
         case (idx)
            REG_FILE_KEY_LOW:     keys.file_lo = value;
            REG_FILE_KEY_HIGH:    keys.file_hi = value[31:0];
            REG_RECEIPT_KEY_LOW:  keys.rcpt_lo = value;
            REG_RECEIPT_KEY_HIGH: keys.rcpt_hi = value[31:0];
            default: ;
         endcase
      endfunction

      function logic [63:0] le_bytes(int first, int len);
         logic [63:0] v;
         v = '0;
         for (int i = len - 1; i >= 0; i--) v = {v[55:0], hdr_seen[first + i]};
         return v;
      endfunction

      function bit key_hit(logic [63:0] lo, logic [31:0] hi);
         return (le_bytes(0, 8) == lo) && (le_bytes(8, 4) == {32'b0, hi});
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // advance the deframer model by one byte transfer
      function void note_byte(logic [7:0] b);
         rsp_payload_type e;
         bit is_file;
         bit is_rcpt;
         e = '0;
         e.out_byte = b;
         case (ph)
            PH_COLLECT: begin
               hdr_seen[hdr_count] = b;
               e.header_pos = 7'(hdr_count);
               e.kind = KIND_HEADER;
               if (hdr_count + 1 < HDR_LEN) begin
                  hdr_count++;
               end else begin
                  is_file = key_hit(keys.file_lo, keys.file_hi);
                  is_rcpt = key_hit(keys.rcpt_lo, keys.rcpt_hi);
                  hdr_count = 0;
                  if (is_rcpt) begin
                     e.receipt_type  = 32'(le_bytes(50, 4));
                     e.receipt_error = 32'(le_bytes(54, 4));
                     e.reply_port    = 32'(le_bytes(58, 4));
                  end
                  if (is_file) begin
                     e.kind         = KIND_FILE;
                     e.file_size    = le_bytes(82, 8);
                     e.write_offset = le_bytes(90, 8);
                     e.part_index   = 32'(le_bytes(98, 4));
                     e.part_count   = 32'(le_bytes(102, 4));
                     e.reply_port   = 32'(le_bytes(106, 4));
                     next_offset    = e.write_offset;
                     ph             = PH_PAYLOAD;
                  end else if (is_rcpt) begin
                     e.kind = KIND_RECEIPT;
                     ph     = PH_IGNORE;
                  end else begin
                     e.kind = KIND_UNMATCHED;
                     ph     = PH_IGNORE;
                  end
               end
            end
            PH_PAYLOAD: begin
               e.kind         = KIND_PAYLOAD;
               e.write_offset = next_offset;
               next_offset    = next_offset + 64'd1;
            end
            default: begin
               e.kind = KIND_IGNORED;
            end
         endcase
         expected_q.push_back(e);
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      task check_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            report("result transfer with nothing outstanding");
            return;
         end
         want = expected_q.pop_front();
         kind_count[int'(want.kind)]++;
         check_field("kind", 64'(got.kind), 64'(want.kind));
         check_field("out_byte", 64'(got.out_byte), 64'(want.out_byte));
         check_field("header_pos", 64'(got.header_pos), 64'(want.header_pos));
         check_field("write_offset", got.write_offset, want.write_offset);
         check_field("file_size", got.file_size, want.file_size);
         check_field("part_index", 64'(got.part_index), 64'(want.part_index));
         check_field("part_count", 64'(got.part_count), 64'(want.part_count));
         check_field("reply_port", 64'(got.reply_port), 64'(want.reply_port));
         check_field("receipt_type", 64'(got.receipt_type), 64'(want.receipt_type));
         check_field("receipt_error", 64'(got.receipt_error), 64'(want.receipt_error));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   hdf_req_if req_bus ();
   hdf_rsp_if rsp_bus ();

   deframe_scoreboard sb;
   logic [7:0]        frame_hdr [HDR_LEN];
   int                rsp_hold;
   bit                steady_flow;
   int                quiet_cycles;
   rsp_payload_type   seen_rsp;

   header_deframer_with_offset #(.HEADER_BYTES(HDR_LEN)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task csr_write(reg_index_type idx, logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(int'(idx) * 8);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      sb.set_key(idx, value);
      @(posedge clock);
   endtask

   task write_keys(logic [95:0] fkey, logic [95:0] rkey, logic [31:0] spare);
      csr_write(REG_FILE_KEY_LOW, fkey[63:0]);
      csr_write(REG_FILE_KEY_HIGH, {spare, fkey[95:64]});
      csr_write(REG_RECEIPT_KEY_LOW, rkey[63:0]);
      csr_write(REG_RECEIPT_KEY_HIGH, {spare, rkey[95:64]});
   endtask

   task send_byte(logic [7:0] b);
      if (!steady_flow && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_byte(b);
   endtask

   task drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold) @(posedge clock);
            rsp_hold = 0;
         end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_rsp.kind          = rsp_bus.kind;
            seen_rsp.out_byte      = rsp_bus.out_byte;
            seen_rsp.header_pos    = rsp_bus.header_pos;
            seen_rsp.write_offset  = rsp_bus.write_offset;
            seen_rsp.file_size     = rsp_bus.file_size;
            seen_rsp.part_index    = rsp_bus.part_index;
            seen_rsp.part_count    = rsp_bus.part_count;
            seen_rsp.reply_port    = rsp_bus.reply_port;
            seen_rsp.receipt_type  = rsp_bus.receipt_type;
            seen_rsp.receipt_error = rsp_bus.receipt_error;
            sb.check_result(seen_rsp);
         end
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      hdr_case_type hcase;
      logic [95:0]  fkey;
      logic [95:0]  rkey;
      logic [95:0]  hkey;
      logic [63:0]  start_off;
      int           pick;

      sb              = new();
      reset           = 1'b1;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      req_bus.valid   = 1'b0;
      req_bus.in_byte = '0;
      rsp_hold        = 0;
      steady_flow     = 1'b0;
      quiet_cycles    = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      pick  = $urandom_range(0, 9);
      hcase = (pick < 6) ? HDR_FILE : (pick < 8) ? HDR_BOTH :
              (pick < 9) ? HDR_RECEIPT : HDR_UNKNOWN;
      fkey  = {$urandom, $urandom, $urandom};
      if ($urandom_range(0, 3) == 0) fkey = '1;
      rkey  = {$urandom, $urandom, $urandom};
      if (hcase == HDR_BOTH) rkey = fkey;
      if (hcase != HDR_BOTH && rkey == fkey) rkey[0] = ~rkey[0];
      case (hcase)
         HDR_RECEIPT: hkey = rkey;
         HDR_UNKNOWN: hkey = (rkey == (fkey ^ 96'd1)) ? (fkey ^ 96'd2) : (fkey ^ 96'd1);
         default:     hkey = fkey;
      endcase
      write_keys(fkey, rkey, $urandom);

      // build the header: key, extremes, random fields, offset close to wrap
      foreach (frame_hdr[i]) frame_hdr[i] = 8'($urandom);
      for (int i = 0; i < 12; i++) frame_hdr[i] = hkey[8*i +: 8];
      frame_hdr[12] = 8'h00;
      frame_hdr[13] = 8'hFF;
      start_off = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 600));
      for (int i = 0; i < 8; i++) frame_hdr[90 + i] = start_off[8*i +: 8];

      for (int i = 0; i < HDR_LEN; i++) send_byte(frame_hdr[i]);
      send_byte(8'h00);
      send_byte(8'hFF);
      drain();

      write_keys('1, '1, '1);
      rsp_hold = HOLD_CYCLES;
      for (int i = 0; i < MID_BYTES; i++) send_byte(8'($urandom));
      drain();

      write_keys('0, '0, '0);
      steady_flow = 1'b1;
      for (int i = 0; i < TAIL_BYTES; i++) send_byte(8'($urandom));
      drain();

      $display("run covered header case %s: %0d header bytes, %0d file, %0d receipt,",
               hcase.name(), sb.kind_count[KIND_HEADER], sb.kind_count[KIND_FILE],
               sb.kind_count[KIND_RECEIPT]);
      $display("  %0d unmatched, %0d payload and %0d ignored results, %0d mismatches",
               sb.kind_count[KIND_UNMATCHED], sb.kind_count[KIND_PAYLOAD],
               sb.kind_count[KIND_IGNORED], sb.errors);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/hdf_pkg.sv
hw/rtl/hdf_ifs.sv
hw/rtl/hdf_csr.sv
hw/rtl/hdf_capture.sv
hw/rtl/header_deframer_with_offset.sv
hw/rtl/hdf_checker.sv
bench/testbench.sv
